// File: hw/rtl/assert_macros.svh
// Concurrent assertion helpers. Each use names clk and rst_n of the
// enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MWE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define MWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MWE_ASSERT_IMP(lbl, ante, cons)

`define MWE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/mwe_pkg.sv
`default_nettype none

package mwe_pkg;

  localparam int RAW_W = 16;
  localparam int VEL_W = 16;
  localparam int THR_W = 12;
  localparam int ABS_W = 29;

  localparam logic [THR_W-1:0] THR_RESET = 12'd30;
  localparam logic [VEL_W-1:0] VEL_SIGN  = 16'h8000;

  typedef enum logic {
    REQ_SAMPLE   = 1'b0,
    REQ_VELOCITY = 1'b1
  } req_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_RANGE_ERR = 1'b1;

  // per-item state update controls, step logic -> wheel registers
  typedef struct packed {
    logic upd_sample;  // write position, turn count, seeded
    logic upd_dir;     // write direction latch
    logic dir_fwd;     // new direction value
    logic status;
  } upd_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mwe_step.sv
`default_nettype none

module mwe_step #(
  parameter int POSITION_BITS = 12,
  parameter int TURN_BITS     = 16
) (
  input  wire logic                             req_type,
  input  wire logic                             wheel_ok,
  input  wire logic [mwe_pkg::RAW_W-1:0]        raw_position,
  input  wire logic signed [mwe_pkg::VEL_W-1:0] velocity,
  input  wire logic [mwe_pkg::THR_W-1:0]        jump_threshold,
  input  wire logic                             seeded,
  input  wire logic                             forward_dir,
  input  wire logic [POSITION_BITS-1:0]         last_position,
  input  wire logic [TURN_BITS-1:0]             turn_count,
  output mwe_pkg::upd_ctl_t                     ctl,
  output logic [POSITION_BITS-1:0]              new_position,
  output logic [TURN_BITS-1:0]                  new_turn_count,
  output logic signed [mwe_pkg::ABS_W-1:0]      abs_position,
  output logic [mwe_pkg::VEL_W-1:0]             velocity_word
);
  import mwe_pkg::*;

  localparam int CMP_W = (POSITION_BITS > THR_W) ? POSITION_BITS : THR_W;
  localparam int TP_W  = TURN_BITS + POSITION_BITS;

  logic                     is_cmd;
  logic                     out_of_range;
  logic                     sample_ok;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] prev;
  logic [POSITION_BITS-1:0] diff;
  logic [TURN_BITS-1:0]     cnt;
  logic                     jump;
  logic signed [TP_W-1:0]   turn_pos;
  logic [VEL_W-1:0]         vel_u;
  logic [VEL_W-1:0]         mag;
  logic                     vel_nz;
  logic                     vel_neg;

  assign is_cmd       = (req_type == REQ_VELOCITY);
  assign out_of_range = ((raw_position >> POSITION_BITS) != '0);
  assign sample_ok    = !is_cmd && wheel_ok && !out_of_range;
  assign pos          = POSITION_BITS'(raw_position);

  // first sample seeds: previous = current, count cleared
  assign prev = seeded ? last_position : pos;
  assign cnt  = seeded ? turn_count : '0;
  assign diff = (pos >= prev) ? (pos - prev) : (prev - pos);
  assign jump = (CMP_W'(diff) > CMP_W'(jump_threshold));

  always_comb begin
    new_turn_count = cnt;
    if (jump && forward_dir && (pos < prev)) begin
      new_turn_count = cnt + TURN_BITS'(1);
    end else if (jump && !forward_dir && (pos > prev)) begin
      new_turn_count = cnt - TURN_BITS'(1);
    end
  end

  assign new_position = pos;
  // count * 2^POSITION_BITS + pos is just the concatenation
  assign turn_pos     = {new_turn_count, pos};
  assign abs_position = sample_ok ? ABS_W'(turn_pos) : '0;

  assign vel_u   = velocity;
  assign vel_nz  = (vel_u != '0);
  assign vel_neg = vel_u[VEL_W-1];
  assign mag     = ~vel_u + VEL_W'(1);

  always_comb begin
    velocity_word = '0;
    if (is_cmd && vel_nz) begin
      velocity_word = vel_neg ? (mag | VEL_SIGN) : vel_u;
    end
  end

  assign ctl.upd_sample = sample_ok;
  assign ctl.upd_dir    = is_cmd && vel_nz && wheel_ok;
  assign ctl.dir_fwd    = !vel_neg;
  assign ctl.status     = (!is_cmd && !sample_ok) ? STATUS_RANGE_ERR : STATUS_OK;

endmodule

`default_nettype wire

// File: hw/rtl/multiturn_wheel_encoder_tracker_unit.sv
// Channel   Handshake             Payload
// in_       in_valid / in_stall   in_req_type, in_wheel, in_raw_position, in_velocity
// out_      out_valid / out_stall out_status, out_abs_position, out_velocity_word
// cfg_      cfg_wr_en             cfg_wr_data (jump threshold)
//
// One item per cycle sustained while out_stall is low; an accepted item passes through
// the input register, then the result register, where it shows as out_valid.
// Per-wheel state is read for the item in the input register and written as the item
// moves into the result register, so consecutive items on a wheel chain directly.
// rst_n (sync, low) clears wheel state, threshold to 30, and both valid flags.
// in_stall rises only when the input register is full and the result is stalled.
`default_nettype none

module multiturn_wheel_encoder_tracker_unit #(
  parameter int POSITION_BITS = 12,
  parameter int TURN_BITS     = 16,
  parameter int WHEEL_COUNT   = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_req_type,
  input  wire logic                              in_wheel,
  input  wire logic [mwe_pkg::RAW_W-1:0]         in_raw_position,
  input  wire logic signed [mwe_pkg::VEL_W-1:0]  in_velocity,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_status,
  output logic signed [mwe_pkg::ABS_W-1:0]       out_abs_position,
  output logic [mwe_pkg::VEL_W-1:0]              out_velocity_word,
  input  wire logic                              cfg_wr_en,
  input  wire logic [mwe_pkg::THR_W-1:0]         cfg_wr_data
);
  import mwe_pkg::*;

`include "assert_macros.svh"

  localparam int WIDX = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

  logic [THR_W-1:0]         jump_thr_r;

  // input register
  logic                     in_v_r;
  logic                     req_r;
  logic                     wheel_r;
  logic [RAW_W-1:0]         raw_r;
  logic signed [VEL_W-1:0]  vel_r;

  // result register
  logic                     out_v_r;
  logic                     status_r;
  logic signed [ABS_W-1:0]  abs_r;
  logic [VEL_W-1:0]         vword_r;

  // wheel state
  logic [POSITION_BITS-1:0] last_pos_r [WHEEL_COUNT];
  logic [TURN_BITS-1:0]     turn_r     [WHEEL_COUNT];
  logic [WHEEL_COUNT-1:0]   seeded_r;
  logic [WHEEL_COUNT-1:0]   fwd_r;

  logic                     advance;
  logic                     fire;
  logic                     wheel_ok;
  logic [WIDX-1:0]          idx;
  upd_ctl_t                 ctl;
  logic [POSITION_BITS-1:0] new_pos;
  logic [TURN_BITS-1:0]     new_turn;
  logic signed [ABS_W-1:0]  abs_nxt;
  logic [VEL_W-1:0]         vword_nxt;

  assign advance  = !out_v_r || !out_stall;
  assign fire     = in_v_r && advance;
  assign in_stall = in_v_r && !advance;

  assign wheel_ok = (32'(wheel_r) < WHEEL_COUNT);
  assign idx      = wheel_ok ? WIDX'(wheel_r) : '0;

  mwe_step #(
    .POSITION_BITS(POSITION_BITS),
    .TURN_BITS    (TURN_BITS)
  ) u_step (
    .req_type      (req_r),
    .wheel_ok      (wheel_ok),
    .raw_position  (raw_r),
    .velocity      (vel_r),
    .jump_threshold(jump_thr_r),
    .seeded        (seeded_r[idx]),
    .forward_dir   (fwd_r[idx]),
    .last_position (last_pos_r[idx]),
    .turn_count    (turn_r[idx]),
    .ctl           (ctl),
    .new_position  (new_pos),
    .new_turn_count(new_turn),
    .abs_position  (abs_nxt),
    .velocity_word (vword_nxt)
  );

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      jump_thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r   <= in_req_type;
      wheel_r <= in_wheel;
      raw_r   <= in_raw_position;
      vel_r   <= in_velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= ctl.status;
      abs_r    <= abs_nxt;
      vword_r  <= vword_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= '0;
      fwd_r    <= '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        last_pos_r[i] <= '0;
        turn_r[i]     <= '0;
      end
    end else if (fire) begin
      if (ctl.upd_sample) begin
        seeded_r[idx]   <= 1'b1;
        last_pos_r[idx] <= new_pos;
        turn_r[idx]     <= new_turn;
      end
      if (ctl.upd_dir) begin
        fwd_r[idx] <= ctl.dir_fwd;
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_status        = status_r;
  assign out_abs_position  = abs_r;
  assign out_velocity_word = vword_r;

  `MWE_ASSERT_NEXT(a_held_item_kept, in_v_r && in_stall, in_v_r)
  `MWE_ASSERT_IMP(a_stall_needs_full_out, in_stall, out_v_r && out_stall)
  `MWE_ASSERT_IMP(a_error_zero_fields, out_v_r && out_status,
                  (out_abs_position == '0) && (out_velocity_word == '0))
  `MWE_ASSERT_NEXT(a_seed_sticky, seeded_r[0], seeded_r[0])
  `MWE_ASSERT_IMP(a_cmd_no_sample_upd, fire && (req_r == REQ_VELOCITY), !ctl.upd_sample)

endmodule

`default_nettype wire

// File: verif/wheel_tracker_checker.sv
module wheel_tracker_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_req_type,
  input  logic                             in_wheel,
  input  logic [mwe_pkg::RAW_W-1:0]        in_raw_position,
  input  logic signed [mwe_pkg::VEL_W-1:0] in_velocity,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_status,
  input  logic [mwe_pkg::ABS_W-1:0]        out_abs_position,
  input  logic [mwe_pkg::VEL_W-1:0]        out_velocity_word,
  input  logic                             cfg_wr_en,
  input  logic [mwe_pkg::THR_W-1:0]        cfg_wr_data,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mwe_pkg::*;

  localparam int POS_W   = 12;
  localparam int TURN_W  = 16;
  localparam int POS_MAX = 4095;

  typedef struct packed {
    logic             status;
    logic [ABS_W-1:0] abs_pos;
    logic [VEL_W-1:0] vel_word;
  } reading_t;

  logic [THR_W-1:0]  jump_thr;
  logic [POS_W-1:0]  last_pos [2];
  logic [TURN_W-1:0] turns [2];
  bit                seeded [2];
  bit                dir_fwd [2];

  reading_t expected_q [$];
  reading_t want;
  int       errs;
  bit       took_in;
  bit       took_out;

  assign fail_count = errs;

  // Advances one wheel's tracking state and returns the reading it should produce.
  function automatic reading_t track_item(req_t kind, logic w, logic [RAW_W-1:0] raw,
                                          logic [VEL_W-1:0] vel);
    reading_t         r;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] gap;
    logic [VEL_W-1:0] mag;
    r = '0;
    if (kind == REQ_VELOCITY) begin
      if (vel != '0) begin
        mag = -vel;
        r.vel_word = vel[VEL_W-1] ? (mag | VEL_SIGN) : vel;
        dir_fwd[w] = !vel[VEL_W-1];
      end
      return r;
    end
    if (raw > POS_MAX) begin
      r.status = STATUS_RANGE_ERR;
      return r;
    end
    pos = raw[POS_W-1:0];
    if (!seeded[w]) begin
      seeded[w] = 1'b1;
      last_pos[w] = pos;
      turns[w] = '0;
    end
    gap = (pos >= last_pos[w]) ? pos - last_pos[w] : last_pos[w] - pos;
    if (gap > jump_thr) begin
      if (dir_fwd[w] && pos < last_pos[w])
        turns[w] = turns[w] + 1'b1;
      else if (!dir_fwd[w] && pos > last_pos[w])
        turns[w] = turns[w] - 1'b1;
    end
    // sign-extended count above the position; position < 4096 so no carry
    r.abs_pos = {turns[w][TURN_W-1], turns[w], pos};
    last_pos[w] = pos;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      jump_thr = THR_RESET;
      for (int i = 0; i < 2; i++) begin
        last_pos[i] = '0;
        turns[i] = '0;
        seeded[i] = 1'b0;
        dir_fwd[i] = 1'b0;
      end
      expected_q.delete();
      pending <= 0;
    end else begin
      took_in = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (cfg_wr_en)
        jump_thr = cfg_wr_data;
      // compare before queuing so a stray result cannot match a fresh item
      if (took_out) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d, abs_position %0d, velocity_word 0x%04h",
                 out_status, $signed(out_abs_position), out_velocity_word);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errs++;
          end
          if (out_abs_position !== want.abs_pos) begin
            $error("abs_position: expected %0d, actual %0d",
                   $signed(want.abs_pos), $signed(out_abs_position));
            errs++;
          end
          if (out_velocity_word !== want.vel_word) begin
            $error("velocity_word: expected 0x%04h, actual 0x%04h",
                   want.vel_word, out_velocity_word);
            errs++;
          end
        end
      end
      if (took_in)
        expected_q.push_back(track_item(req_t'(in_req_type), in_wheel, in_raw_position,
                                        in_velocity));
      pending <= expected_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mwe_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int POS_MAX     = 4095;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_req_type = 1'b0;
  logic                    in_wheel = 1'b0;
  logic [RAW_W-1:0]        in_raw_position = '0;
  logic signed [VEL_W-1:0] in_velocity = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_status;
  logic [ABS_W-1:0]        out_abs_position;
  logic [VEL_W-1:0]        out_velocity_word;
  logic                    cfg_wr_en = 1'b0;
  logic [THR_W-1:0]        cfg_wr_data = '0;
  int                      fail_count;
  int                      pending;

  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int cur_thr = 30;
  int cur_pos [2] = '{0, 0};
  logic [VEL_W-1:0] odd_vels [6] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h8001, 16'hFFFF,
                                     16'h0001};

  multiturn_wheel_encoder_tracker_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_wheel         (in_wheel),
    .in_raw_position  (in_raw_position),
    .in_velocity      (in_velocity),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_abs_position (out_abs_position),
    .out_velocity_word(out_velocity_word),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  wheel_tracker_checker chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: switches between free-running, light, heavy and alternating stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 2);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // Valid stays up after an accept while the burst lasts; the caller must not
  // let time pass between items without ending the burst (see settle).
  task automatic push(req_t kind, logic w, logic [RAW_W-1:0] raw, logic [VEL_W-1:0] vel);
    in_req_type <= kind;
    in_wheel <= w;
    in_raw_position <= raw;
    in_velocity <= vel;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (kind == REQ_SAMPLE && raw <= POS_MAX)
      cur_pos[w] = raw;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 25) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(int v);
    settle();
    cfg_wr_data <= THR_W'(v);
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_thr = v;
  endtask

  task automatic directed_items();
    push(REQ_SAMPLE,   1'b1, 16'hFFFF, 16'h7FFF);  // out of range before seeding
    push(REQ_SAMPLE,   1'b1, 16'd4096, 16'h0000);
    push(REQ_SAMPLE,   1'b0, 16'd4095, 16'h8000);  // seeds wheel 0
    push(REQ_SAMPLE,   1'b0, 16'd0,    16'h0000);  // reverse, drop: no step
    push(REQ_SAMPLE,   1'b0, 16'd4095, 16'h0000);  // reverse, rise: count down
    push(REQ_VELOCITY, 1'b0, 16'hFFFF, 16'h0000);  // zero keeps direction
    push(REQ_VELOCITY, 1'b0, 16'h0000, 16'h0001);
    push(REQ_SAMPLE,   1'b0, 16'd10,   16'hFFFF);  // forward wrap: count up
    push(REQ_SAMPLE,   1'b0, 16'd40,   16'h0000);  // jump equal to threshold
    push(REQ_SAMPLE,   1'b0, 16'd5,    16'h0000);
    push(REQ_VELOCITY, 1'b0, 16'h0000, 16'hFFFF);
    push(REQ_VELOCITY, 1'b1, 16'h0000, 16'h7FFF);
    push(REQ_VELOCITY, 1'b1, 16'h0000, 16'h8001);
    push(REQ_VELOCITY, 1'b1, 16'h0000, 16'h8000);  // magnitude wraps to zero
    push(REQ_VELOCITY, 1'b1, 16'h0000, 16'h7FFF);
    push(REQ_SAMPLE,   1'b1, 16'd0,    16'h0000);  // seeds wheel 1
    push(REQ_SAMPLE,   1'b1, 16'd4095, 16'h0000);
    push(REQ_SAMPLE,   1'b1, 16'd0,    16'h0000);
    push(REQ_SAMPLE,   1'b0, 16'd4095, 16'h0000);
    push(REQ_SAMPLE,   1'b0, 16'd4096, 16'h0000);  // error leaves state alone
    push(REQ_SAMPLE,   1'b0, 16'd4095, 16'h0000);
    push(REQ_VELOCITY, 1'b0, 16'hAAAA, 16'h5555);
    push(REQ_VELOCITY, 1'b1, 16'h5555, 16'hAAAA);
  endtask

  // Threshold 0 and a slow forward descent step the count up on each falling sample; a
  // longer reverse ascent then steps it down through zero so the counter wraps.
  task automatic turn_wrap_sweep();
    int p;
    set_threshold(0);
    push(REQ_VELOCITY, 1'b0, 16'($urandom), 16'd100);
    p = POS_MAX;
    repeat (20) begin
      push(REQ_SAMPLE, 1'b0, 16'(p), 16'($urandom));
      p = (p == 0) ? POS_MAX : p - 1;
    end
    push(REQ_VELOCITY, 1'b0, 16'($urandom), -16'sd100);
    repeat (60) begin
      p = (p == POS_MAX) ? 0 : p + 1;
      push(REQ_SAMPLE, 1'b0, 16'(p), 16'($urandom));
    end
  endtask

  task automatic random_items(int n);
    int       sel;
    int       delta;
    int       np;
    logic     w;
    logic [VEL_W-1:0] vel;
    repeat (n) begin
      w = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        np = -1;
        delta = 0;
        case ($urandom_range(0, 3))
          0: delta = int'($urandom_range(0, 2 * cur_thr)) - cur_thr;
          1: delta = (cur_thr + int'($urandom_range(1, 40))) * ($urandom_range(0, 1) ? 1 : -1);
          2: np = (cur_pos[w] >= 2048) ? $urandom_range(0, 40) : $urandom_range(4055, POS_MAX);
          default: np = $urandom_range(0, POS_MAX);
        endcase
        if (np < 0)
          np = ((cur_pos[w] + delta) % 4096 + 4096) % 4096;
        push(REQ_SAMPLE, w, 16'(np), 16'($urandom));
      end else if (sel < 75) begin
        case ($urandom_range(0, 3))
          0: vel = 16'($urandom);
          1: vel = 16'($urandom_range(1, 200));
          2: vel = -16'($urandom_range(1, 200));
          default: vel = odd_vels[$urandom_range(0, 5)];
        endcase
        push(REQ_VELOCITY, w, 16'($urandom), vel);
      end else if (sel < 85) begin
        push(REQ_SAMPLE, w, 16'($urandom_range(4096, 65535)), 16'($urandom));
      end else if (sel < 92) begin
        push(req_t'(1'($urandom_range(0, 1))), w, 16'($urandom), 16'($urandom));
      end else begin
        push(REQ_SAMPLE, w, $urandom_range(0, 1) ? 16'd0 : 16'(POS_MAX), 16'($urandom));
      end
    end
  endtask

  initial begin
    int thr_plan [8];
    thr_plan = '{4095, 0, 1, $urandom_range(2, 400), 2048, $urandom_range(2, 4094), 30, 4094};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    turn_wrap_sweep();
    foreach (thr_plan[i]) begin
      set_threshold(thr_plan[i]);
      random_items(180);
    end
    settle();
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
